FILE: rtl/core/lcs_pkg.sv
`timescale 1ns / 1ps

package lcs_pkg;

   localparam int RUN_W               = 6;
   localparam int BYTE_W              = 8;
   localparam int CSR_DATA_W          = 64;
   localparam int CSR_INDEX_W         = 3;
   localparam int PATTERN_MAX_DEFAULT = 32;
   // pattern bytes backed by the four pattern registers
   localparam int REG_PATTERN_BYTES   = 32;

   typedef logic [RUN_W-1:0]  run_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam run_type RUN_MAX = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_0 = 3'd0,
      CSR_PATTERN_1 = 3'd1,
      CSR_PATTERN_2 = 3'd2,
      CSR_PATTERN_3 = 3'd3,
      CSR_LENGTH    = 3'd4
   } csr_index_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic     step;
      logic     clear;
      byte_type text_byte;
   } cell_ctrl_type;

   function automatic run_type max_run(input run_type a, input run_type b);
      return (a > b) ? a : b;
   endfunction

endpackage

FILE: rtl/core/lcs_cell.sv
`timescale 1ns / 1ps

module lcs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lcs_pkg::cell_ctrl_type ctrl,
   input  lcs_pkg::byte_type      pattern_byte,
   input  logic                   active,
   input  lcs_pkg::run_type       left_run,
   output lcs_pkg::run_type       run
);
   import lcs_pkg::*;

   run_type run_ff;
   run_type run_in;

   always_comb begin
      run_in = run_ff;
      if (ctrl.clear) begin
         run_in = '0;
      end else if (ctrl.step) begin
         if (active && (pattern_byte == ctrl.text_byte)) begin
            // extend the diagonal run of the left neighbour, saturating
            run_in = (left_run == RUN_MAX) ? RUN_MAX : run_type'(left_run + 1'b1);
         end else begin
            run_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   assign run = run_ff;

endmodule

FILE: rtl/core/lcs_max_tree.sv
`timescale 1ns / 1ps

module lcs_max_tree #(
   parameter int N = lcs_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic [N*lcs_pkg::RUN_W-1:0]   leaves,
   output lcs_pkg::run_type              root
);
   import lcs_pkg::*;

   localparam int LEVELS = (N > 1) ? $clog2(N) : 0;
   localparam int LEAVES = 1 << LEVELS;

   run_type leaf_w [0:LEAVES-1];

   genvar k;
   generate
      for (k = 0; k < LEAVES; k++) begin : g_leaf
         if (k < N) begin : g_real
            assign leaf_w[k] = leaves[k*RUN_W +: RUN_W];
         end else begin : g_pad
            assign leaf_w[k] = '0;
         end
      end

      if (LEAVES > 1) begin : g_tree
         // heap order: node 1 is the root, children of i are 2i and 2i+1
         run_type node_ff [1:LEAVES-1];
         genvar i;
         for (i = 1; i < LEAVES; i++) begin : g_node
            if (2 * i >= LEAVES) begin : g_bottom
               always_ff @(posedge clock) begin
                  node_ff[i] <= max_run(leaf_w[2*i-LEAVES], leaf_w[2*i+1-LEAVES]);
               end
            end else begin : g_inner
               always_ff @(posedge clock) begin
                  node_ff[i] <= max_run(node_ff[2*i], node_ff[2*i+1]);
               end
            end
         end
         assign root = node_ff[1];
      end else begin : g_single
         assign root = leaf_w[0];
      end
   endgenerate

endmodule

FILE: rtl/core/longest_common_substring.sv
`timescale 1ns / 1ps

// Streaming longest common substring against a pattern of up to 32 bytes.
// Configuration: write the four pattern registers and the length through
// csr_write / csr_index / csr_wdata while no word is in flight.
// Request channel: one text byte per word, req_text_last marks the end of a
// text. Response channel: one word per request with the longest run ending at
// that byte, the best run so far in this text and the end-of-text flag.
// A request steps the cell row; its result then passes through the
// registered max tree, clog2(PATTERN_MAX) levels deep (5 at the default size),
// into the response register. One request is in work at a time; the next
// request is taken only after the previous result has left the max tree and
// been registered for the response.
// A finished word sits in the response register; while rsp_stall is high the
// next request can still be accepted and worked on, and the block then
// holds it until the response register frees.
// After a word with req_text_last the run row and the best value clear.
// Reset (synchronous) clears the row, the best value, the pattern and length
// registers and the control state, and drops rsp_valid; no clearing pass is needed.
module longest_common_substring #(
   parameter int PATTERN_MAX = lcs_pkg::PATTERN_MAX_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lcs_pkg::byte_type                 req_text_byte,
   input  logic                              req_text_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lcs_pkg::run_type                  rsp_run_ending_here,
   output lcs_pkg::run_type                  rsp_best_length,
   output logic                              rsp_text_done,
   input  logic                              csr_write,
   input  logic [lcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lcs_pkg::*;

   localparam int LAT   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 0;
   localparam int CNT_W = (LAT > 0) ? $clog2(LAT + 1) : 1;

   logic [CSR_DATA_W-1:0] pattern_ff [0:3];
   logic [RUN_W-1:0]      pattern_length_ff;

   logic             busy_ff;
   logic [CNT_W-1:0] count_ff;
   logic             last_ff;
   run_type          best_ff;
   logic             rsp_valid_ff;
   run_type          rsp_run_ff;
   run_type          rsp_best_ff;
   logic             rsp_done_ff;

   logic          req_accept;
   logic          done_now;
   cell_ctrl_type cell_ctrl;
   run_type       root;
   run_type       best_in;
   logic [PATTERN_MAX*RUN_W-1:0] row_w;

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !req_stall;
   assign done_now   = busy_ff && (count_ff == CNT_W'(LAT)) && (!rsp_valid_ff || !rsp_stall);

   assign cell_ctrl.step      = req_accept;
   assign cell_ctrl.clear     = done_now && last_ff;
   assign cell_ctrl.text_byte = req_text_byte;

   genvar j;
   generate
      for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
         byte_type pat_byte;
         logic     active;
         run_type  left_run;
         run_type  run;

         if (j < REG_PATTERN_BYTES) begin : g_backed
            assign pat_byte = pattern_ff[j/8][(j%8)*BYTE_W +: BYTE_W];
            // lengths above 32 behave as 32 since only these cells compare
            assign active   = pattern_length_ff > RUN_W'(j);
         end else begin : g_unbacked
            assign pat_byte = '0;
            assign active   = 1'b0;
         end

         if (j == 0) begin : g_first
            assign left_run = '0;
         end else begin : g_chain
            assign left_run = row_w[(j-1)*RUN_W +: RUN_W];
         end

         lcs_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (cell_ctrl),
            .pattern_byte (pat_byte),
            .active       (active),
            .left_run     (left_run),
            .run          (run)
         );

         assign row_w[j*RUN_W +: RUN_W] = run;
      end
   endgenerate

   lcs_max_tree #(
      .N (PATTERN_MAX)
   ) u_max_tree (
      .clock  (clock),
      .leaves (row_w),
      .root   (root)
   );

   assign best_in = max_run(best_ff, root);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff[0]     <= '0;
         pattern_ff[1]     <= '0;
         pattern_ff[2]     <= '0;
         pattern_ff[3]     <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_0: pattern_ff[0]     <= csr_wdata;
            CSR_PATTERN_1: pattern_ff[1]     <= csr_wdata;
            CSR_PATTERN_2: pattern_ff[2]     <= csr_wdata;
            CSR_PATTERN_3: pattern_ff[3]     <= csr_wdata;
            CSR_LENGTH:    pattern_length_ff <= csr_wdata[RUN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            last_ff  <= req_text_last;
         end else if (busy_ff && (count_ff != CNT_W'(LAT))) begin
            // wait for the max tree to settle on the new row
            count_ff <= count_ff + 1'b1;
         end

         if (done_now) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_run_ff   <= root;
            rsp_best_ff  <= best_in;
            rsp_done_ff  <= last_ff;
            best_ff      <= last_ff ? '0 : best_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_run_ending_here = rsp_run_ff;
   assign rsp_best_length     = rsp_best_ff;
   assign rsp_text_done       = rsp_done_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LAT))
      else $error("settle counter ran past tree depth");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff && (count_ff == '0))
      else $error("accepted word did not start work");

   a_best_covers_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_best_ff >= rsp_run_ff))
      else $error("best length below run length");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_run_ff <= RUN_W'(REG_PATTERN_BYTES)))
      else $error("run longer than the pattern registers");

   a_text_end_clears: assert property (@(posedge clock) disable iff (reset)
      (done_now && last_ff) |=> (best_ff == '0) && (row_w == '0))
      else $error("state not cleared after end of text");

endmodule

FILE: sim/tb_longest_common_substring.sv
`timescale 1ns / 1ps

module tb_longest_common_substring;
   import lcs_pkg::*;

   localparam int PATTERN_SIZE = PATTERN_MAX_DEFAULT;
   // indexes above the length register decode to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 3'd5;
   localparam int IDLE_PERCENT = 12;
   localparam int FLUSH_CYCLES = 8;
   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 100;
   localparam int HOLD_OFF_LENGTH = 200;

   typedef struct {
      run_type run_ending_here;
      run_type best_length;
      logic    text_done;
   } text_result_type;

   class run_scoreboard;
      logic [CSR_DATA_W-1:0] pattern_words[4];
      logic [RUN_W-1:0]      length_reg;
      run_type               run_row[PATTERN_SIZE];
      run_type               best_run;
      text_result_type       awaited[$];
      int                    errors;

      function new();
         foreach (pattern_words[w]) pattern_words[w] = '0;
         foreach (run_row[p]) run_row[p] = '0;
         length_reg = '0;
         best_run = '0;
         errors = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] value);
         if (index < CSR_LENGTH) pattern_words[index] = value;
         else if (index == CSR_LENGTH) length_reg = value[RUN_W-1:0];
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // one step of the run row, highest position first so each cell sees its old left value
      function void note_text_word(byte_type text, logic last);
         int span;
         run_type longest;
         text_result_type result;
         span = (length_reg > REG_PATTERN_BYTES) ? REG_PATTERN_BYTES : int'(length_reg);
         if (span > PATTERN_SIZE) span = PATTERN_SIZE;
         longest = '0;
         for (int pos = PATTERN_SIZE - 1; pos >= 0; pos--) begin
            run_type grown;
            grown = '0;
            if (pos < span && pattern_words[pos / 8][(pos % 8) * BYTE_W +: BYTE_W] == text) begin
               if (pos == 0) grown = run_type'(1);
               else if (run_row[pos - 1] == RUN_MAX) grown = RUN_MAX;
               else grown = run_row[pos - 1] + 1'b1;
            end
            run_row[pos] = grown;
            if (grown > longest) longest = grown;
         end
         if (longest > best_run) best_run = longest;
         result.run_ending_here = longest;
         result.best_length = best_run;
         result.text_done = last;
         awaited.push_back(result);
         if (last) begin
            foreach (run_row[p]) run_row[p] = '0;
            best_run = '0;
         end
      endfunction

      function void check_result(run_type run, run_type best, logic done);
         text_result_type want;
         if (awaited.size() == 0) begin
            $error("unexpected result word: run %0d best %0d done %0b", run, best, done);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (run !== want.run_ending_here) begin
            $error("run_ending_here expected %0d actual %0d", want.run_ending_here, run);
            errors++;
         end
         if (best !== want.best_length) begin
            $error("best_length expected %0d actual %0d", want.best_length, best);
            errors++;
         end
         if (done !== want.text_done) begin
            $error("text_done expected %0b actual %0b", want.text_done, done);
            errors++;
         end
      endfunction

      function void close_out();
         if (awaited.size() != 0) begin
            $error("%0d expected result words never arrived", awaited.size());
            errors += awaited.size();
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   byte_type               req_text_byte = '0;
   logic                   req_text_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   run_type                rsp_run_ending_here;
   run_type                rsp_best_length;
   logic                   rsp_text_done;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   run_scoreboard runs_sb = new();
   byte_type      pattern_image[PATTERN_SIZE];
   int            text_span = 0;
   bit            gaps_on = 1'b1;
   int            hold_off_cycles = 0;

   longest_common_substring DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_text_byte       (req_text_byte),
      .req_text_last       (req_text_last),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_run_ending_here (rsp_run_ending_here),
      .rsp_best_length     (rsp_best_length),
      .rsp_text_done       (rsp_text_done),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off so the block backs up
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles--;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         runs_sb.check_result(rsp_run_ending_here, rsp_best_length, rsp_text_done);
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_word(byte_type text, logic last);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= text;
      req_text_last <= last;
      do @(posedge clock); while (req_stall);
      runs_sb.note_text_word(text, last);
   endtask

   // stop offering words and let every result come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (runs_sb.pending() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      runs_sb.write_register(index, value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic program_pattern(int len);
      logic [CSR_DATA_W-1:0] packed_word;
      drain();
      for (int w = 0; w < 4; w++) begin
         for (int b = 0; b < 8; b++) packed_word[b * BYTE_W +: BYTE_W] = pattern_image[w * 8 + b];
         write_csr(csr_index_type'(CSR_PATTERN_0 + w), packed_word);
      end
      write_csr(CSR_LENGTH, CSR_DATA_W'(len));
      text_span = (len > PATTERN_SIZE) ? PATTERN_SIZE : len;
   endtask

   initial begin
      int       roll;
      int       style;
      int       cursor;
      byte_type text;
      byte_type symbols[3];

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing matches while the length is still zero
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);

      foreach (pattern_image[p]) pattern_image[p] = byte_type'(p);
      pattern_image[PATTERN_SIZE - 1] = '1;
      program_pattern(PATTERN_SIZE);
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h02, 1'b0);
      send_word(8'hFF, 1'b0);
      // run that ends on the top pattern position
      send_word(8'h1D, 1'b0);
      send_word(8'h1E, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h02, 1'b1);
      send_word(8'h00, 1'b1);

      // row is kept across a length write in the middle of a text; 40 acts as 32
      send_word(8'h00, 1'b0);
      send_word(8'h01, 1'b0);
      drain();
      write_csr(CSR_LENGTH, CSR_DATA_W'(40));
      send_word(8'h02, 1'b0);
      drain();
      for (int idx = CSR_INDEX_UNUSED; idx < (1 << CSR_INDEX_W); idx++)
         write_csr(idx[CSR_INDEX_W-1:0], '1);
      send_word(8'h03, 1'b1);
      drain();
      write_csr(CSR_LENGTH, CSR_DATA_W'(1));
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b1);

      foreach (pattern_image[p]) pattern_image[p] = '1;
      program_pattern((1 << RUN_W) - 1);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'hFF, 1'b1);
      drain();
      write_csr(CSR_LENGTH, CSR_DATA_W'(0));
      send_word(8'hFF, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         foreach (symbols[s]) symbols[s] = byte_type'($urandom);
         style = $urandom_range(2);
         foreach (pattern_image[p])
            case (style)
               0: pattern_image[p] = byte_type'($urandom);
               1: pattern_image[p] = symbols[$urandom_range(2)];
               default: pattern_image[p] = ($urandom_range(7) == 0) ? symbols[1] : symbols[0];
            endcase
         roll = (phase < 5) ? phase : $urandom_range(2);
         case (roll)
            0: program_pattern(PATTERN_SIZE);
            1: program_pattern($urandom_range((1 << RUN_W) - 1, PATTERN_SIZE + 1));
            2: program_pattern($urandom_range(PATTERN_SIZE, 2));
            3: program_pattern(1);
            default: program_pattern(0);
         endcase
         gaps_on = (phase != 2);
         if (phase == 5) hold_off_cycles = HOLD_OFF_LENGTH;
         cursor = 0;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            // mostly copies of pattern stretches, some jumps and some noise
            if (text_span == 0 || roll >= 85) begin
               text = byte_type'($urandom);
            end else begin
               if (roll >= 70) cursor = $urandom_range(text_span - 1);
               text = pattern_image[cursor];
               cursor = (cursor + 1) % text_span;
            end
            send_word(text, $urandom_range(39) == 0);
         end
      end

      drain();
      runs_sb.close_out();
      if (runs_sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
